// ===== rtl/thermal_raster_band_formatter_top_assert.svh =====
// assertion macros for the raster band formatter
`ifndef THERMAL_RASTER_BAND_FORMATTER_TOP_ASSERT_SVH
`define THERMAL_RASTER_BAND_FORMATTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define TRBF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// checked at every edge, reset included
`define TRBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRBF_ASSERT(lbl, clk, rstn, prop, msg)
`define TRBF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/trbf_pkg.sv =====
// shared types and constants of the raster band formatter
`timescale 1ns / 1ps
package trbf_pkg;

    localparam int MAX_WIDTH  = 384;
    localparam int MAX_HEIGHT = 900;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WB_MAX = (MAX_WIDTH + 7) / 8;
    localparam int WB_W   = $clog2(WB_MAX + 1);
    localparam int HCMP_W = (ROW_W > 8) ? ROW_W : 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_BAND_HEIGHT      = 3'd2,
        REG_BLACK_THRESHOLD  = 3'd3,
        REG_FINISH_FEED_DOTS = 3'd4
    } cfg_reg_t;

    localparam logic [8:0] RST_IMAGE_WIDTH      = 9'd384;
    localparam logic [9:0] RST_IMAGE_HEIGHT     = 10'd900;
    localparam logic [7:0] RST_BAND_HEIGHT      = 8'd24;
    localparam logic [8:0] RST_BLACK_THRESHOLD  = 9'd140;
    localparam logic [7:0] RST_FINISH_FEED_DOTS = 8'd32;

    // luma weights
    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd151;
    localparam logic [15:0] LUMA_B = 16'd28;

    // printer command bytes
    localparam logic [7:0] CMD_ESC    = 8'h1B;
    localparam logic [7:0] CMD_AT     = 8'h40;
    localparam logic [7:0] CMD_GS     = 8'h1D;
    localparam logic [7:0] CMD_V      = 8'h76;
    localparam logic [7:0] CMD_RASTER = 8'h30;
    localparam logic [7:0] CMD_MODE   = 8'h00;
    localparam logic [7:0] CMD_FEED_J = 8'h4A;

    // byte slots of one record, in emission order
    localparam int NUM_SLOTS = 16;
    typedef logic [3:0] slot_t;
    localparam slot_t SLOT_INIT_ESC = 4'd0;
    localparam slot_t SLOT_INIT_AT  = 4'd1;
    localparam slot_t SLOT_HDR_GS   = 4'd2;
    localparam slot_t SLOT_HDR_V    = 4'd3;
    localparam slot_t SLOT_HDR_MODE = 4'd4;
    localparam slot_t SLOT_HDR_M    = 4'd5;
    localparam slot_t SLOT_HDR_WBL  = 4'd6;
    localparam slot_t SLOT_HDR_WBH  = 4'd7;
    localparam slot_t SLOT_HDR_HL   = 4'd8;
    localparam slot_t SLOT_HDR_HH   = 4'd9;
    localparam slot_t SLOT_DOTS     = 4'd10;
    localparam slot_t SLOT_END_ESC  = 4'd11;
    localparam slot_t SLOT_END_J    = 4'd12;
    localparam slot_t SLOT_END_FEED = 4'd13;
    localparam slot_t SLOT_RST_ESC  = 4'd14;
    localparam slot_t SLOT_RST_AT   = 4'd15;

    // one classified pixel: which byte groups it produces and their data
    typedef struct packed {
        logic            init;
        logic            hdr;
        logic            dot;
        logic            trl;
        logic [7:0]      dot_byte;
        logic [WB_W-1:0] wb;
        logic [7:0]      bh;
        logic [7:0]      feed;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } q_head_t;

endpackage

// ===== rtl/trbf_front.sv =====
// front end: config registers, pixel thresholding, packing and band tracking
`timescale 1ns / 1ps
module trbf_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,
    input  logic                             q_room,
    output logic                             push,
    output trbf_pkg::rec_t                   push_rec
);

    logic [8:0] width_reg;
    logic [9:0] height_reg;
    logic [7:0] band_reg;
    logic [8:0] thr_reg;
    logic [7:0] feed_reg;

    logic [trbf_pkg::COL_W-1:0] column_reg, column_next;
    logic [7:0]                 rib_reg, rib_next;
    logic [trbf_pkg::ROW_W-1:0] rows_reg, rows_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [2:0]                 bitpos_reg, bitpos_next;
    logic                       started_reg, started_next;

    logic [trbf_pkg::COL_W-1:0]  eff_w;
    logic [trbf_pkg::ROW_W-1:0]  eff_h;
    logic [7:0]                  eff_band;
    logic [trbf_pkg::COL_W:0]    col_inc;
    logic [trbf_pkg::ROW_W:0]    rows_inc;
    logic [8:0]                  rib_inc;
    logic [trbf_pkg::ROW_W-1:0]  h_left;
    logic [7:0]                  bh;
    logic [7:0]                  r8, g8, b8;
    logic [15:0]                 luma_sum;
    logic                        black;
    logic [7:0]                  dot_val;
    logic                        row_end, job_end, emit_dot, hdr, accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_room;
    assign accept    = s_tvalid && q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= trbf_pkg::RST_IMAGE_WIDTH;
            height_reg <= trbf_pkg::RST_IMAGE_HEIGHT;
            band_reg   <= trbf_pkg::RST_BAND_HEIGHT;
            thr_reg    <= trbf_pkg::RST_BLACK_THRESHOLD;
            feed_reg   <= trbf_pkg::RST_FINISH_FEED_DOTS;
        end else if (cfg_valid) begin
            case (cfg_index)
                trbf_pkg::REG_IMAGE_WIDTH:      width_reg  <= cfg_data[8:0];
                trbf_pkg::REG_IMAGE_HEIGHT:     height_reg <= cfg_data[9:0];
                trbf_pkg::REG_BAND_HEIGHT:      band_reg   <= cfg_data[7:0];
                trbf_pkg::REG_BLACK_THRESHOLD:  thr_reg    <= cfg_data[8:0];
                trbf_pkg::REG_FINISH_FEED_DOTS: feed_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective geometry: zero acts as one, oversize clamps
    always_comb begin
        if (width_reg == 9'd0) begin
            eff_w = trbf_pkg::COL_W'(1);
        end else if (32'(width_reg) > 32'(trbf_pkg::MAX_WIDTH)) begin
            eff_w = trbf_pkg::COL_W'(trbf_pkg::MAX_WIDTH);
        end else begin
            eff_w = trbf_pkg::COL_W'(width_reg);
        end
        if (height_reg == 10'd0) begin
            eff_h = trbf_pkg::ROW_W'(1);
        end else if (32'(height_reg) > 32'(trbf_pkg::MAX_HEIGHT)) begin
            eff_h = trbf_pkg::ROW_W'(trbf_pkg::MAX_HEIGHT);
        end else begin
            eff_h = trbf_pkg::ROW_W'(height_reg);
        end
        eff_band = (band_reg == 8'd0) ? 8'd1 : band_reg;
    end

    // luma and threshold
    always_comb begin
        r8 = {s_tdata[15:11], s_tdata[15:13]};
        g8 = {s_tdata[10:5], s_tdata[10:9]};
        b8 = {s_tdata[4:0], s_tdata[4:2]};
        luma_sum = 16'(r8) * trbf_pkg::LUMA_R + 16'(g8) * trbf_pkg::LUMA_G
                 + 16'(b8) * trbf_pkg::LUMA_B;
        black = {1'b0, luma_sum[15:8]} < thr_reg;
    end

    always_comb begin
        col_inc  = {1'b0, column_reg} + 1'b1;
        rows_inc = {1'b0, rows_reg} + 1'b1;
        rib_inc  = {1'b0, rib_reg} + 1'b1;
        row_end  = col_inc >= {1'b0, eff_w};
        job_end  = row_end && (rows_inc >= {1'b0, eff_h});
        emit_dot = (bitpos_reg == 3'd7) || row_end;
        hdr      = (column_reg == '0) && (rib_reg == 8'd0);
        dot_val  = shift_reg | (black ? (8'h80 >> bitpos_reg) : 8'h00);

        // rows declared in the header: what is left, capped by the band, and one once none are left
        h_left = eff_h - rows_reg;
        if (rows_reg >= eff_h) begin
            bh = 8'd1;
        end else if (trbf_pkg::HCMP_W'(h_left) > trbf_pkg::HCMP_W'(eff_band)) begin
            bh = eff_band;
        end else begin
            bh = h_left[7:0];
        end

        push_rec.init     = !started_reg;
        push_rec.hdr      = hdr;
        push_rec.dot      = emit_dot;
        push_rec.trl      = job_end;
        push_rec.dot_byte = dot_val;
        push_rec.wb       = trbf_pkg::WB_W'(({1'b0, eff_w} + 7'd7) >> 3);
        push_rec.bh       = bh;
        push_rec.feed     = feed_reg;
        push = accept && (!started_reg || hdr || emit_dot);

        column_next  = column_reg;
        rib_next     = rib_reg;
        rows_next    = rows_reg;
        shift_next   = shift_reg;
        bitpos_next  = bitpos_reg;
        started_next = started_reg;
        if (accept) begin
            started_next = 1'b1;
            shift_next   = emit_dot ? 8'h00 : dot_val;
            bitpos_next  = emit_dot ? 3'd0 : bitpos_reg + 3'd1;
            column_next  = row_end ? '0 : col_inc[trbf_pkg::COL_W-1:0];
            if (row_end) begin
                rows_next = rows_inc[trbf_pkg::ROW_W-1:0];
                rib_next  = (rib_inc >= {1'b0, eff_band}) ? 8'd0 : rib_inc[7:0];
                if (job_end) begin
                    rows_next    = '0;
                    rib_next     = 8'd0;
                    started_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            rib_reg     <= 8'd0;
            rows_reg    <= '0;
            shift_reg   <= 8'd0;
            bitpos_reg  <= 3'd0;
            started_reg <= 1'b0;
        end else begin
            column_reg  <= column_next;
            rib_reg     <= rib_next;
            rows_reg    <= rows_next;
            shift_reg   <= shift_next;
            bitpos_reg  <= bitpos_next;
            started_reg <= started_next;
        end
    end

endmodule

// ===== rtl/trbf_queue.sv =====
// small record queue between the front and back ends
`timescale 1ns / 1ps
module trbf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  trbf_pkg::rec_t     push_rec,
    output logic               room,
    input  logic               pop,
    output trbf_pkg::q_head_t  head
);

    trbf_pkg::rec_t mem_reg [trbf_pkg::Q_DEPTH];

    logic [trbf_pkg::Q_PTR_W-1:0] wr_reg, wr_next;
    logic [trbf_pkg::Q_PTR_W-1:0] rd_reg, rd_next;
    logic [trbf_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign room       = cnt_reg < trbf_pkg::Q_CNT_W'(trbf_pkg::Q_DEPTH);
    assign head.valid = cnt_reg != '0;
    assign head.rec   = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/trbf_back.sv =====
// back end: walks the byte slots of the head record into the output register
`timescale 1ns / 1ps
module trbf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  trbf_pkg::q_head_t  head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    logic                     valid_reg, valid_next;
    logic [7:0]               data_reg, data_next;
    logic                     last_reg, last_next;
    trbf_pkg::slot_t          pos_reg, pos_next;

    logic [trbf_pkg::NUM_SLOTS-1:0] en, cand;
    trbf_pkg::slot_t                sel;
    logic                           more, fire;
    logic [15:0]                    wb16;
    logic [7:0]                     sel_byte;

    always_comb begin
        en = '0;
        en[trbf_pkg::SLOT_INIT_ESC] = head.rec.init;
        en[trbf_pkg::SLOT_INIT_AT]  = head.rec.init;
        for (int i = trbf_pkg::SLOT_HDR_GS; i <= trbf_pkg::SLOT_HDR_HH; i++) begin
            en[i] = head.rec.hdr;
        end
        en[trbf_pkg::SLOT_DOTS] = head.rec.dot;
        for (int i = trbf_pkg::SLOT_END_ESC; i <= trbf_pkg::SLOT_RST_AT; i++) begin
            en[i] = head.rec.trl;
        end

        // slots at or after the current position
        for (int i = 0; i < trbf_pkg::NUM_SLOTS; i++) begin
            cand[i] = en[i] && (trbf_pkg::slot_t'(i) >= pos_reg);
        end
        sel = trbf_pkg::SLOT_RST_AT;
        for (int i = trbf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                sel = trbf_pkg::slot_t'(i);
            end
        end
        more = 1'b0;
        for (int i = 0; i < trbf_pkg::NUM_SLOTS; i++) begin
            if (cand[i] && (trbf_pkg::slot_t'(i) > sel)) begin
                more = 1'b1;
            end
        end

        wb16 = 16'(head.rec.wb);
        case (sel)
            trbf_pkg::SLOT_INIT_ESC: sel_byte = trbf_pkg::CMD_ESC;
            trbf_pkg::SLOT_INIT_AT:  sel_byte = trbf_pkg::CMD_AT;
            trbf_pkg::SLOT_HDR_GS:   sel_byte = trbf_pkg::CMD_GS;
            trbf_pkg::SLOT_HDR_V:    sel_byte = trbf_pkg::CMD_V;
            trbf_pkg::SLOT_HDR_MODE: sel_byte = trbf_pkg::CMD_RASTER;
            trbf_pkg::SLOT_HDR_M:    sel_byte = trbf_pkg::CMD_MODE;
            trbf_pkg::SLOT_HDR_WBL:  sel_byte = wb16[7:0];
            trbf_pkg::SLOT_HDR_WBH:  sel_byte = wb16[15:8];
            trbf_pkg::SLOT_HDR_HL:   sel_byte = head.rec.bh;
            trbf_pkg::SLOT_HDR_HH:   sel_byte = 8'h00;
            trbf_pkg::SLOT_DOTS:     sel_byte = head.rec.dot_byte;
            trbf_pkg::SLOT_END_ESC:  sel_byte = trbf_pkg::CMD_ESC;
            trbf_pkg::SLOT_END_J:    sel_byte = trbf_pkg::CMD_FEED_J;
            trbf_pkg::SLOT_END_FEED: sel_byte = head.rec.feed;
            trbf_pkg::SLOT_RST_ESC:  sel_byte = trbf_pkg::CMD_ESC;
            trbf_pkg::SLOT_RST_AT:   sel_byte = trbf_pkg::CMD_AT;
            default:                 sel_byte = 8'h00;
        endcase

        fire = head.valid && (!valid_reg || m_tready);
        pop  = fire && !more;

        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        if (fire) begin
            valid_next = 1'b1;
            data_next  = sel_byte;
            last_next  = sel == trbf_pkg::SLOT_RST_AT;
            pos_next   = more ? sel + 1'b1 : trbf_pkg::SLOT_INIT_ESC;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= trbf_pkg::SLOT_INIT_ESC;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/thermal_raster_band_formatter_top.sv =====
// top level of the thermal printer raster band formatter
`timescale 1ns / 1ps
// Turns a raster-order stream of RGB565 pixels into a thermal printer command
// byte stream: ESC @ before a job, a GS v 0 header (1D 76 30 00 wbL wbH hL hH)
// in front of every band of up to band_height rows, the dots packed MSB first
// with each row zero-padded to a whole byte, and ESC J feed plus ESC @ after
// the last row (m_tlast marks that closing 0x40). A pixel is black when its
// luma (77r + 151g + 28b) >> 8 is strictly below black_threshold. The front
// end takes one pixel per cycle, classifies it and, if it causes any bytes,
// pushes a record of those byte groups into a 4-entry queue; the back end
// sends one byte per cycle from the queue head through a registered output
// while m_tready allows. A pixel that starts a band or ends the job produces
// up to 16 bytes, and the input stalls only once the queue is full. The first
// byte of a pixel passes through the queue and then the output register.
// Config writes are taken every cycle and are meant for idle periods; a new
// width, height or band height applies from the next pixel on.
module thermal_raster_band_formatter_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // pixel[15:0]
    // command byte output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // out_byte[7:0]
    output logic                             m_tlast    // last byte of the job
);

`include "thermal_raster_band_formatter_top_assert.svh"

    logic               push, room, pop;
    trbf_pkg::rec_t     push_rec;
    trbf_pkg::q_head_t  head;

    // pixel classification and row / band bookkeeping
    trbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_room   (room),
        .push     (push),
        .push_rec (push_rec)
    );

    // decouples header bursts from the pixel stream
    trbf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_rec(push_rec),
        .room    (room),
        .pop     (pop),
        .head    (head)
    );

    // byte sequencer and output register
    trbf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // the job always closes with ESC @
    `TRBF_ASSERT(a_last_is_at, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata == trbf_pkg::CMD_AT), "last byte is not ESC @ terminator")
    // a job ends on a row end, so the trailer always follows a dot byte
    `TRBF_ASSERT(a_trailer_has_dots, aclk, aresetn, (push && push_rec.trl) |-> push_rec.dot, "trailer queued without final dot byte")
    // only records that produce bytes are queued
    `TRBF_ASSERT(a_head_nonempty, aclk, aresetn, head.valid |-> (head.rec.init || head.rec.hdr || head.rec.dot || head.rec.trl), "empty record in queue")

endmodule

// ===== bench/raster_stream_checker.sv =====
// checker for the raster band formatter: predicts the command byte stream and compares it
`timescale 1ns / 1ps
module raster_stream_checker
    import trbf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cmd_byte_t;

    cmd_byte_t expected_bytes[$];
    cmd_byte_t want;

    // register copies
    logic [8:0] width_reg;
    logic [9:0] height_reg;
    logic [7:0] band_reg;
    logic [8:0] thresh_reg;
    logic [7:0] feed_reg;

    // raster position and partial dot byte
    logic [8:0] col;
    logic [7:0] band_row;
    logic [9:0] rows_done;
    logic [7:0] dots;
    logic [3:0] bit_pos;
    logic       job_open;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_count = fail_count + 1;
    endtask

    function automatic void expect_byte(input logic [7:0] data, input logic last);
        cmd_byte_t item;
        item.data = data;
        item.last = last;
        expected_bytes.push_back(item);
    endfunction

    function automatic logic [7:0] pixel_luma(input logic [15:0] pix);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [17:0] sum;
        r = {pix[15:11], pix[15:13]};
        g = {pix[10:5], pix[10:9]};
        b = {pix[4:0], pix[4:2]};
        sum = r * LUMA_R + g * LUMA_G + b * LUMA_B;
        return sum[15:8];
    endfunction

    task automatic format_pixel(input logic [15:0] pix);
        logic [8:0]  w;
        logic [9:0]  h;
        logic [7:0]  band;
        logic [15:0] row_bytes;
        logic [15:0] band_rows;
        w = (width_reg == 0) ? 9'd1 : (width_reg > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_reg;
        h = (height_reg == 0) ? 10'd1 :
            (height_reg > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : height_reg;
        band = (band_reg == 0) ? 8'd1 : band_reg;
        row_bytes = (16'(w) + 16'd7) >> 3;

        if (!job_open) begin
            expect_byte(CMD_ESC, 1'b0);
            expect_byte(CMD_AT, 1'b0);
            job_open = 1'b1;
        end

        if (col == 0 && band_row == 0) begin
            // rows left in the image, capped by the band; never below one
            band_rows = 16'd1;
            if (rows_done < h) begin
                band_rows = 16'(h - rows_done);
                if (band_rows > 16'(band))
                    band_rows = 16'(band);
            end
            expect_byte(CMD_GS, 1'b0);
            expect_byte(CMD_V, 1'b0);
            expect_byte(CMD_RASTER, 1'b0);
            expect_byte(CMD_MODE, 1'b0);
            expect_byte(row_bytes[7:0], 1'b0);
            expect_byte(row_bytes[15:8], 1'b0);
            expect_byte(band_rows[7:0], 1'b0);
            expect_byte(band_rows[15:8], 1'b0);
        end

        if (9'(pixel_luma(pix)) < thresh_reg)
            dots[3'd7 - bit_pos[2:0]] = 1'b1;
        bit_pos = bit_pos + 4'd1;
        col = col + 9'd1;

        if (bit_pos >= 4'd8 || col >= w) begin
            expect_byte(dots, 1'b0);
            dots = '0;
            bit_pos = '0;
        end

        if (col >= w) begin
            col = '0;
            rows_done = rows_done + 10'd1;
            band_row = band_row + 8'd1;
            if (band_row >= band || rows_done >= h)
                band_row = '0;
            if (rows_done >= h) begin
                expect_byte(CMD_ESC, 1'b0);
                expect_byte(CMD_FEED_J, 1'b0);
                expect_byte(feed_reg, 1'b0);
                expect_byte(CMD_ESC, 1'b0);
                expect_byte(CMD_AT, 1'b1);
                rows_done = '0;
                band_row = '0;
                job_open = 1'b0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            band_reg   = RST_BAND_HEIGHT;
            thresh_reg = RST_BLACK_THRESHOLD;
            feed_reg   = RST_FINISH_FEED_DOTS;
            col        = '0;
            band_row   = '0;
            rows_done  = '0;
            dots       = '0;
            bit_pos    = '0;
            job_open   = 1'b0;
            fail_count = 0;
            expected_bytes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:      width_reg  = cfg_data[8:0];
                    REG_IMAGE_HEIGHT:     height_reg = cfg_data[9:0];
                    REG_BAND_HEIGHT:      band_reg   = cfg_data[7:0];
                    REG_BLACK_THRESHOLD:  thresh_reg = cfg_data[8:0];
                    REG_FINISH_FEED_DOTS: feed_reg   = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                format_pixel(s_tdata);

            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("byte got %02h want %02h",
                                                  m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast got %b want %b on byte %02h",
                                                  m_tlast, want.last, want.data));
                end
            end
        end
        pending_count <= expected_bytes.size();
    end

endmodule

// ===== bench/tb.sv =====
// testbench top: pixel and config stimulus for the raster band formatter, plus the verdict
`timescale 1ns / 1ps
module tb;
    import trbf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 600000;
    // extra wait after draining, as margin for a pixel still in flight
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PIXELS = 350;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // shadow of the width and height, used to size each phase
    int cur_w = RST_IMAGE_WIDTH;
    int cur_h = RST_IMAGE_HEIGHT;

    // sender burst state
    int burst_left = 0;
    bit in_burst   = 1'b0;

    // receiver stall pattern
    logic [8:0] stall_phase = '0;

    thermal_raster_band_formatter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    raster_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // receiver: four repeating stretches picked by stall_phase[8:7] - always ready,
    // mostly ready, one cycle in eight, and on/off blocks set by stall_phase[4]
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 2) != 0);
            2'd2: m_tready <= (stall_phase[2:0] == 3'd0);
            default: m_tready <= stall_phase[4];
        endcase
    end

    // one config transfer; valid stays high so writes can chain back to back
    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // write the registers picked by mask (bit i = register index i)
    task automatic program_regs(input logic [4:0] mask, input int w, input int h,
                                input int band, input int thresh, input int feed);
        bit any;
        any = 1'b0;
        if (mask[REG_IMAGE_WIDTH]) begin
            write_reg(REG_IMAGE_WIDTH, w);
            cur_w = w;
            any = 1'b1;
        end
        if (mask[REG_IMAGE_HEIGHT]) begin
            write_reg(REG_IMAGE_HEIGHT, h);
            cur_h = h;
            any = 1'b1;
        end
        if (mask[REG_BAND_HEIGHT]) begin
            write_reg(REG_BAND_HEIGHT, band);
            any = 1'b1;
        end
        if (mask[REG_BLACK_THRESHOLD]) begin
            write_reg(REG_BLACK_THRESHOLD, thresh);
            any = 1'b1;
        end
        if (mask[REG_FINISH_FEED_DOTS]) begin
            write_reg(REG_FINISH_FEED_DOTS, feed);
            any = 1'b1;
        end
        if (any)
            cfg_valid <= 1'b0;
    endtask

    // one pixel transfer; bursts of random length with idle gaps between them,
    // so tvalid is never dropped and raised in the same step
    task automatic send_pixel(input logic [15:0] pix);
        if (!in_burst) begin
            s_tvalid <= 1'b1;
            in_burst = 1'b1;
        end
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            in_burst = 1'b0;
            burst_left = $urandom_range(0, 39);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic stop_input();
        if (in_burst) begin
            s_tvalid <= 1'b0;
            in_burst = 1'b0;
        end
    endtask

    // hold the sender until every predicted byte has come out
    task automatic wait_drained();
        stop_input();
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // idle point for config writes: drained, plus time for a pixel in flight
    // that produces no byte
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // black and white extremes often, so both dot values show up in runs
    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int count;
        int wi;
        int hi;
        int w;
        int h;
        int band;
        int thresh;
        int feed;
        logic [4:0] mask;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: init, header with 48 bytes per row and 24 rows,
        // then black, white and the three pure channels
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        settle();

        // zero width, height and band act as one; mid-row shrink ends the job
        // at once; threshold of 256 prints everything black
        program_regs(5'b11111, 0, 0, 0, 256, 255);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h8410);
        settle();

        // 3-wide rows with padding, one row per band, oversized threshold
        program_regs(5'b11111, 3, 3, 1, 511, 0);
        repeat (6) send_pixel(pick_pixel());
        settle();

        // height drops below the rows already done: header declares one row
        program_regs(5'b00010, 3, 1, 1, 511, 0);
        repeat (3) send_pixel(pick_pixel());
        settle();

        // widest and tallest fields, widest band, nothing black
        program_regs(5'b11111, 511, 1023, 255, 0, 128);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0821);
        settle();

        // random phases: mostly whole images with random pixels, some cut
        // short so the next settings land mid-job
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            settle();
            mask = 5'($urandom_range(0, 31));
            if (cur_w > 64) mask[REG_IMAGE_WIDTH] = 1'b1;
            if (cur_h > 40) mask[REG_IMAGE_HEIGHT] = 1'b1;
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 511) : $urandom_range(0, 24);
            h = ($urandom_range(0, 11) == 0) ? $urandom_range(700, 1023) : $urandom_range(0, 6);
            band = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 255)
                                               : $urandom_range(0, 4);
            thresh = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                                 : $urandom_range(0, 256);
            feed = $urandom_range(0, 255);
            program_regs(mask, w, h, band, thresh, feed);

            wi = (cur_w == 0) ? 1 : (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
            hi = (cur_h == 0) ? 1 : (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
            count = wi * hi;
            if (count > 80)
                count = $urandom_range(1, 48);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, count);

            for (int i = 0; i < count; i++) begin
                // now and then let the output run dry mid-phase
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                send_pixel(pick_pixel());
            end
            sent += count;
        end

        settle();
        if (fail_count == 0)
            $display("[thermal_raster_band_formatter_top] OK");
        else
            $display("[thermal_raster_band_formatter_top] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[thermal_raster_band_formatter_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/trbf_pkg.sv
rtl/trbf_front.sv
rtl/trbf_queue.sv
rtl/trbf_back.sv
rtl/thermal_raster_band_formatter_top.sv
bench/raster_stream_checker.sv
bench/tb.sv
